### hdl/mwo_pkg.sv
`default_nettype none
package mwo_pkg;

    localparam int TABLE_LEN = 2048;
    localparam int NUM_WAVES = 16;
    localparam int NUM_BANDS = 12;

    localparam int IDX_W      = $clog2(TABLE_LEN);
    localparam int FRAC_W     = 16;
    localparam int PHASE_W    = IDX_W + FRAC_W;
    localparam int ADDR_W     = 19;
    localparam int ROW_W      = ADDR_W - IDX_W;
    localparam int STORE_SIZE = NUM_WAVES * NUM_BANDS * TABLE_LEN;

    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 24;
    localparam int POS_W    = 20;
    localparam int MIX_W    = 17;
    localparam int NOTE_W   = 7;
    localparam int SRATE_W  = 18;
    localparam int BAND_W   = 4;
    localparam int WAVE_W   = POS_W - FRAC_W;
    localparam int STEP_W   = 32;

    localparam int DVD_W    = 40;
    localparam int MUL_XW   = RATE_W + 1;
    localparam int MUL_YW   = MIX_W + 1;
    localparam int MUL_PW   = MUL_XW + MUL_YW;

    localparam logic [SRATE_W-1:0] SRATE_RESET = SRATE_W'(44100);
    localparam logic [MUL_YW-1:0]  BASE_RATE   = MUL_YW'(44100);
    localparam logic [RATE_W-1:0]  RATE_FLOOR  = RATE_W'(655);
    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(65536);
    localparam logic [MIX_W-1:0]   MIX_FULL    = MIX_W'(65536);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // note / 10 by reciprocal (exact below 128), clamped to the last band
    function automatic logic [BAND_W-1:0] note_to_band(input logic [NOTE_W-1:0] note);
        logic [NOTE_W+7:0] prod;
        logic [NOTE_W-1:0] q;
        prod = (NOTE_W+8)'(note) * (NOTE_W+8)'(205);
        q    = NOTE_W'(prod >> 11);
        if (int'(q) > NUM_BANDS - 1)
            return BAND_W'(NUM_BANDS - 1);
        return BAND_W'(q);
    endfunction

endpackage
`default_nettype wire

### hdl/mwo_if.sv
`default_nettype none
interface mwo_req_if import mwo_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [ADDR_W-1:0]    load_addr;
    logic signed [SAMPLE_W-1:0] load_data;
    logic [RATE_W-1:0]    rate;
    logic [POS_W-1:0]     wave_pos_a;
    logic [POS_W-1:0]     wave_pos_b;
    logic [MIX_W-1:0]     mix;
    logic [NOTE_W-1:0]    note;
    modport source (output valid, op, load_addr, load_data, rate, wave_pos_a, wave_pos_b,
                    mix, note, input ready);
    modport sink (input valid, op, load_addr, load_data, rate, wave_pos_a, wave_pos_b,
                  mix, note, output ready);
endinterface

interface mwo_rsp_if import mwo_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       cycle_start;
    modport source (output valid, sample, cycle_start, input ready);
    modport sink (input valid, sample, cycle_start, output ready);
endinterface

interface mwo_cfg_if import mwo_pkg::*;;
    logic               valid;
    logic               ready;
    logic [SRATE_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### hdl/morphing_wavetable_oscillator_top.sv
`default_nettype none
// Load: written at acceptance if inside the store, ready again the next cycle, no result.
// Tick transaction: after acceptance come the table reads through one RAM port, 7 blends on
// one shared multiplier, one multiply and 40 restoring divide steps for the phase step, then
// the result is posted. A new tick is accepted only once the sequencer is back in idle;
// a result still waiting in the output register holds the sequencer in its last state.
// Reset (rst_n, async low): phase 0, step 65536, band 0, output rate register 44100;
// table contents are undefined until loaded.
module morphing_wavetable_oscillator_top import mwo_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    mwo_req_if.sink   req,
    mwo_rsp_if.source rsp,
    mwo_cfg_if.sink   cfg
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_BLEND = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [5:0] cnt_reg;

    logic [SRATE_W-1:0] srate_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [BAND_W-1:0]  band_reg;

    logic [RATE_W-1:0] rate_reg;
    logic [POS_W-1:0]  pos_a_reg, pos_b_reg;
    logic [MIX_W-1:0]  mix_reg;
    logic [NOTE_W-1:0] note_reg;

    logic signed [SAMPLE_W-1:0] pts_reg [8];
    logic signed [SAMPLE_W-1:0] i0_reg, i1_reg, ma_reg, mb_reg, smp_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [SRATE_W-1:0] rem_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_cs_reg;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.sample = out_sample_reg;
    assign rsp.cycle_start = out_cs_reg;

    wire acc      = req.valid && req.ready;
    wire acc_load = acc && (req.op == OP_LOAD);
    wire acc_tick = acc && (req.op == OP_TICK);

    // split phase
    wire [IDX_W-1:0]  idx  = phase_reg[PHASE_W-1:FRAC_W];
    wire [FRAC_W-1:0] frac = phase_reg[FRAC_W-1:0];
    wire [IDX_W-1:0]  nxt  = (int'(idx) < TABLE_LEN - 1) ? idx + IDX_W'(1) : '0;

    // clamp morph positions to the last wave
    localparam logic [POS_W-1:0] POS_TOP = POS_W'((NUM_WAVES - 1) * 65536);
    wire [POS_W-1:0]  pa  = (pos_a_reg > POS_TOP) ? POS_TOP : pos_a_reg;
    wire [POS_W-1:0]  pb  = (pos_b_reg > POS_TOP) ? POS_TOP : pos_b_reg;
    wire [WAVE_W-1:0] wa  = pa[POS_W-1:FRAC_W];
    wire [WAVE_W-1:0] wb  = pb[POS_W-1:FRAC_W];
    wire [WAVE_W-1:0] wa2 = (int'(wa) < NUM_WAVES - 1) ? wa + WAVE_W'(1) : wa;
    wire [WAVE_W-1:0] wb2 = (int'(wb) < NUM_WAVES - 1) ? wb + WAVE_W'(1) : wb;
    wire [MIX_W-1:0]  mixc = (mix_reg > MIX_FULL) ? MIX_FULL : mix_reg;

    // read address for point k: bit2 morph b, bit1 next wave, bit0 next index
    logic [WAVE_W-1:0] rd_wave;
    logic [ROW_W-1:0]  rd_row;
    logic [ADDR_W-1:0] rd_addr;
    always_comb
    begin
        case (cnt_reg[2:1])
            2'd0:    rd_wave = wa;
            2'd1:    rd_wave = wa2;
            2'd2:    rd_wave = wb;
            default: rd_wave = wb2;
        endcase
        rd_row  = ROW_W'(ROW_W'(rd_wave) * ROW_W'(NUM_BANDS) + ROW_W'(band_reg));
        rd_addr = {rd_row, cnt_reg[0] ? nxt : idx};
    end

    // table store
    logic [SAMPLE_W-1:0] ram_rdata;
    wire ram_we = acc_load && (int'(req.load_addr) < STORE_SIZE);
    mwo_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_SIZE)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  ((state_reg == ST_IDLE) ? req.load_addr[$clog2(STORE_SIZE)-1:0]
                                       : rd_addr[$clog2(STORE_SIZE)-1:0]),
        .wdata (req.load_data),
        .rdata (ram_rdata)
    );

    // select blend operands
    logic signed [SAMPLE_W-1:0] op_a, op_b;
    logic [MIX_W-1:0]           op_f;
    always_comb
    begin
        op_a = pts_reg[0];
        op_b = pts_reg[1];
        op_f = MIX_W'(frac);
        case (cnt_reg[2:0])
            3'd0:
            begin
                op_a = pts_reg[0]; op_b = pts_reg[1]; op_f = MIX_W'(frac);
            end
            3'd1:
            begin
                op_a = pts_reg[2]; op_b = pts_reg[3]; op_f = MIX_W'(frac);
            end
            3'd2:
            begin
                op_a = i0_reg; op_b = i1_reg; op_f = MIX_W'(pa[FRAC_W-1:0]);
            end
            3'd3:
            begin
                op_a = pts_reg[4]; op_b = pts_reg[5]; op_f = MIX_W'(frac);
            end
            3'd4:
            begin
                op_a = pts_reg[6]; op_b = pts_reg[7]; op_f = MIX_W'(frac);
            end
            3'd5:
            begin
                op_a = i0_reg; op_b = i1_reg; op_f = MIX_W'(pb[FRAC_W-1:0]);
            end
            default:
            begin
                op_a = ma_reg; op_b = mb_reg; op_f = mixc;
            end
        endcase
    end

    // shared multiplier: a + (b - a) * f for blends, rate * 44100 for the step
    wire [RATE_W-1:0] rate_f = (rate_reg < RATE_FLOOR) ? RATE_FLOOR : rate_reg;
    wire signed [SAMPLE_W:0] diff = (SAMPLE_W+1)'(op_b) - (SAMPLE_W+1)'(op_a);
    logic signed [MUL_XW-1:0] mul_x;
    logic signed [MUL_YW-1:0] mul_y;
    logic signed [MUL_PW-1:0] mul_p;
    always_comb
    begin
        if (state_reg == ST_MUL)
        begin
            mul_x = signed'({1'b0, rate_f});
            mul_y = signed'(BASE_RATE);
        end
        else
        begin
            mul_x = MUL_XW'(diff);
            mul_y = signed'({1'b0, op_f});
        end
        mul_p = mul_x * mul_y;
    end

    // round to nearest, halves up, then saturate
    logic signed [MUL_PW:0]     blend_t;
    logic signed [MUL_PW-16:0]  blend_q;
    logic signed [SAMPLE_W-1:0] blend_r;
    always_comb
    begin
        blend_t = (MUL_PW+1)'(mul_p) + ((MUL_PW+1)'(op_a) <<< 16) + (MUL_PW+1)'(32768);
        blend_q = (MUL_PW-15)'(blend_t >>> 16);
        if (blend_q > (MUL_PW-15)'(32767))
            blend_r = 16'sh7FFF;
        else if (blend_q < -(MUL_PW-15)'(32768))
            blend_r = -16'sh8000;
        else
            blend_r = SAMPLE_W'(blend_q);
    end

    // restoring divide step
    wire [SRATE_W-1:0] divisor = (srate_reg == '0) ? SRATE_W'(1) : srate_reg;
    wire [SRATE_W:0]   rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    wire               q_bit   = (rem_sh >= {1'b0, divisor});
    wire [SRATE_W:0]   rem_sub = rem_sh - {1'b0, divisor};

    // phase advance and next step
    wire [STEP_W:0]     sum    = (STEP_W+1)'(phase_reg) + (STEP_W+1)'(step_reg);
    wire                wrap   = (sum[STEP_W:PHASE_W] != '0);
    wire [STEP_W-1:0]   step_q = (dvd_reg[DVD_W-1:STEP_W] != '0) ? '1 : dvd_reg[STEP_W-1:0];
    wire                out_free = !out_valid_reg || rsp.ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            srate_reg <= SRATE_RESET;
        else if (cfg.valid && cfg.ready)
            srate_reg <= cfg.data;
    end

    // sequencer and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            step_reg      <= STEP_RESET;
            band_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // post a new result, or drop the one taken
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (acc_tick)
                        state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    if (cnt_reg == 6'd8)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_BLEND;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                ST_BLEND:
                begin
                    if (cnt_reg == 6'd6)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                ST_MUL:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (cnt_reg == 6'(DVD_W - 1))
                        state_reg <= ST_DONE;
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        phase_reg <= sum[PHASE_W-1:0];
                        step_reg  <= step_q;
                        if (wrap)
                            band_reg <= note_to_band(note_reg);
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (acc_tick)
        begin
            rate_reg  <= req.rate;
            pos_a_reg <= req.wave_pos_a;
            pos_b_reg <= req.wave_pos_b;
            mix_reg   <= req.mix;
            note_reg  <= req.note;
        end
        if (state_reg == ST_READ && cnt_reg != 6'd0)
            pts_reg[3'(cnt_reg - 6'd1)] <= signed'(ram_rdata);
        if (state_reg == ST_BLEND)
        begin
            case (cnt_reg[2:0])
                3'd0, 3'd3: i0_reg  <= blend_r;
                3'd1, 3'd4: i1_reg  <= blend_r;
                3'd2:       ma_reg  <= blend_r;
                3'd5:       mb_reg  <= blend_r;
                default:    smp_reg <= blend_r;
            endcase
        end
        if (state_reg == ST_MUL)
        begin
            dvd_reg <= DVD_W'(mul_p);
            rem_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[SRATE_W-1:0] : rem_sh[SRATE_W-1:0];
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_sample_reg <= smp_reg;
            out_cs_reg     <= wrap;
        end
    end
endmodule
`default_nettype wire

### hdl/mwo_ram.sv
`default_nettype none
module mwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire
